/* sv/ucw_pkg.sv */
// Package for the UTF-8 column width counter: payload structs, the work packet
// passed from the decode front to the accumulate back, constants and helpers.
// No dependencies.
`default_nettype none

package ucw_pkg;

  // Counter width of positions and columns (8..32)
  localparam int CNT_W = 16;
  // Compare width: wide enough for a counter or the target, plus one carry bit
  localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;
  // Decode-to-accumulate queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [20:0]      code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] column_total;
    logic [15:0] split_offset;
    logic        target_reached;
  } out_item_t;

  // Width events of one input item, in order: first a_cnt width-1 events at
  // a_base, a_base+1, ..., then at most one event of width b_w at b_pos.
  typedef struct packed {
    logic [1:0] a_cnt;
    cnt_t       a_base;
    logic       b_valid;
    logic       b_w;
    cnt_t       b_pos;
    logic       last;
    cnt_t       range_len;
  } work_pkt_t;

  function automatic cnt_t sat_add_cnt(cnt_t a, logic [1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Display width: 0 for NUL, combining marks, zero-width space/joiners, Khmer signs
  function automatic logic width_of(code_t cp);
    logic zero;
    zero = (cp == 21'h0) ||
           (cp >= 21'h0300 && cp <= 21'h036F) ||
           (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
           (cp >= 21'h1DC0 && cp <= 21'h1DFF) ||
           (cp >= 21'h20D0 && cp <= 21'h20FF) ||
           (cp >= 21'hFE20 && cp <= 21'hFE2F) ||
           (cp >= 21'h200B && cp <= 21'h200D) ||
           (cp >= 21'h17B6 && cp <= 21'h17D3) ||
           (cp == 21'h17DD);
    return !zero;
  endfunction

endpackage

`default_nettype wire

/* sv/ucw_front.sv */
// Decode front: accepts bytes, tracks the pending UTF-8 sequence and turns each
// item into a work packet of width events. Depends on ucw_pkg.
`default_nettype none

module ucw_front import ucw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_fire,
  input  wire in_item_t  item,
  output logic           push,
  output work_pkt_t      push_pkt
);

  logic [1:0] needed_r, needed_nxt;
  logic [1:0] held_r, held_nxt;
  code_t      partial_r, partial_nxt;
  cnt_t       lead_r, lead_nxt;
  cnt_t       bpos_r, bpos_nxt;

  logic [7:0] b;
  code_t      code;
  logic [1:0] held_inc;
  logic       a_used;

  always_comb begin
    b           = item.data_byte;
    code        = {partial_r[14:0], b[5:0]};
    held_inc    = 2'(held_r + 2'd1);
    needed_nxt  = needed_r;
    held_nxt    = held_r;
    partial_nxt = partial_r;
    lead_nxt    = lead_r;
    bpos_nxt    = bpos_r;
    a_used      = 1'b0;
    push_pkt    = '0;

    if (item.has_byte) begin
      if (needed_r != 2'd0 && (b & CONT_MASK) == CONT_TAG) begin
        if (held_inc >= needed_r) begin
          push_pkt.b_valid = 1'b1;
          push_pkt.b_w     = width_of(code);
          push_pkt.b_pos   = lead_r;
          needed_nxt       = 2'd0;
          held_nxt         = 2'd0;
          partial_nxt      = '0;
        end else begin
          held_nxt    = held_inc;
          partial_nxt = code;
        end
      end else begin
        // drop the broken sequence as separate width-1 code points
        if (needed_r != 2'd0) begin
          push_pkt.a_cnt  = held_inc;
          push_pkt.a_base = lead_r;
          a_used          = 1'b1;
        end
        held_nxt    = 2'd0;
        needed_nxt  = 2'd0;
        partial_nxt = '0;
        if ((b & ASCII_MASK) == 8'h00) begin
          push_pkt.b_valid = 1'b1;
          push_pkt.b_w     = width_of({13'd0, b});
          push_pkt.b_pos   = bpos_r;
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
          needed_nxt  = 2'd1;
          partial_nxt = {16'd0, b[4:0]};
          lead_nxt    = bpos_r;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
          needed_nxt  = 2'd2;
          partial_nxt = {17'd0, b[3:0]};
          lead_nxt    = bpos_r;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
          needed_nxt  = 2'd3;
          partial_nxt = {18'd0, b[2:0]};
          lead_nxt    = bpos_r;
        end else begin
          push_pkt.b_valid = 1'b1;
          push_pkt.b_w     = 1'b1;
          push_pkt.b_pos   = bpos_r;
        end
      end
      bpos_nxt = sat_add_cnt(bpos_r, 2'd1);
    end

    push_pkt.last = item.last_byte;
    if (item.last_byte) begin
      // range end cuts the sequence short: flush it
      if (needed_nxt != 2'd0) begin
        if (!a_used) begin
          push_pkt.a_cnt  = 2'(held_nxt + 2'd1);
          push_pkt.a_base = lead_nxt;
        end else begin
          push_pkt.b_valid = 1'b1;
          push_pkt.b_w     = 1'b1;
          push_pkt.b_pos   = lead_nxt;
        end
      end
      push_pkt.range_len = bpos_nxt;
      needed_nxt  = 2'd0;
      held_nxt    = 2'd0;
      partial_nxt = '0;
      lead_nxt    = '0;
      bpos_nxt    = '0;
    end

    push = item_fire && (item.has_byte || item.last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r  <= 2'd0;
      held_r    <= 2'd0;
      partial_r <= '0;
      lead_r    <= '0;
      bpos_r    <= '0;
    end else if (item_fire) begin
      needed_r  <= needed_nxt;
      held_r    <= held_nxt;
      partial_r <= partial_nxt;
      lead_r    <= lead_nxt;
      bpos_r    <= bpos_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/ucw_queue.sv */
// Short FIFO of work packets between the decode front and accumulate back.
// Depends on ucw_pkg.
`default_nettype none

module ucw_queue import ucw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire work_pkt_t push_pkt,
  output logic           not_full,
  input  wire logic      pop,
  output logic           not_empty,
  output work_pkt_t      head
);

  work_pkt_t         slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign not_full  = (cnt_r != QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= ptr_inc(wr_r);
      end
      if (do_pop) begin
        rd_r <= ptr_inc(rd_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= QCNT_W'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= QCNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ucw_back.sv */
// Accumulate back: applies a packet's width events to the running column and
// split point, and holds the range result in an output register. Depends on ucw_pkg.
`default_nettype none

module ucw_back import ucw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] target,
  input  wire logic        pkt_valid,
  input  wire work_pkt_t   pkt,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  localparam int EV_N = 4;

  cnt_t      col_r, col_nxt;
  cnt_t      split_r, split_nxt;
  logic      seen_r, seen_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      ev_v   [EV_N];
  logic      ev_w   [EV_N];
  cnt_t      ev_pos [EV_N];
  logic      load;

  always_comb begin
    for (int i = 0; i < EV_N - 1; i++) begin
      ev_v[i]   = (2'(i) < pkt.a_cnt);
      ev_w[i]   = 1'b1;
      ev_pos[i] = sat_add_cnt(pkt.a_base, 2'(i));
    end
    ev_v[EV_N-1]   = pkt.b_valid;
    ev_w[EV_N-1]   = pkt.b_w;
    ev_pos[EV_N-1] = pkt.b_pos;

    col_nxt   = col_r;
    split_nxt = split_r;
    seen_nxt  = seen_r;
    for (int i = 0; i < EV_N; i++) begin
      if (ev_v[i]) begin
        if (!seen_nxt &&
            (CMP_W'(col_nxt) + CMP_W'(ev_w[i]) > CMP_W'(target))) begin
          seen_nxt  = 1'b1;
          split_nxt = ev_pos[i];
        end
        col_nxt = sat_add_cnt(col_nxt, {1'b0, ev_w[i]});
      end
    end

    // stall a range end only while the previous result is still unread
    pop  = pkt_valid && (!pkt.last || !out_valid_r || out_ready);
    load = pop && pkt.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      split_r <= '0;
      seen_r  <= 1'b0;
    end else if (pop) begin
      if (pkt.last) begin
        col_r   <= '0;
        split_r <= '0;
        seen_r  <= 1'b0;
      end else begin
        col_r   <= col_nxt;
        split_r <= split_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.column_total   <= 16'(col_nxt);
      out_data_r.split_offset   <= 16'(seen_nxt ? split_nxt : pkt.range_len);
      out_data_r.target_reached <= seen_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* sv/utf8_column_width_counter_core.sv */
// Top level of the UTF-8 column width counter: decode front, packet queue,
// accumulate back and the target_column register. Depends on ucw_pkg and its submodules.
`default_nettype none

// The block takes one byte of a text range per beat and decodes UTF-8 by lead
// length and continuation checks; each code point adds display width 0 or 1 to
// a saturating column count. A beat with last_byte set closes the range and
// yields one result beat: the total column width, the byte offset of the first
// code point that pushed the column past target_column (or the range length if
// none did), and a flag saying whether that happened. Broken or truncated
// sequences count lead and continuation bytes as width-1 code points. Input
// runs at one byte per clock, sustained: the front decodes a byte combinationally
// and the back folds up to four width events per cycle into the column.
// The closing beat is registered in the queue, its result in the output register;
// the input keeps flowing while a result waits, held back only when the two-entry
// queue fills behind an unread result. Write target_column only while the block is idle.

module utf8_column_width_counter_core import ucw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] target_r;
  logic        item_fire;
  logic        push;
  work_pkt_t   push_pkt;
  logic        q_not_full;
  logic        q_not_empty;
  logic        pop;
  work_pkt_t   head;

  // Config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 16'd0;
    end else if (cfg_valid) begin
      target_r <= cfg_data;
    end
  end

  // Take a byte whenever the queue has room
  assign in_ready  = q_not_full;
  assign item_fire = in_valid && in_ready;

  ucw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (in_data),
    .push      (push),
    .push_pkt  (push_pkt)
  );

  ucw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pkt  (push_pkt),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  ucw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .target    (target_r),
    .pkt_valid (q_not_empty),
    .pkt       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* dv/utf8_column_width_counter_core_test.sv */
// Self-checking testbench for utf8_column_width_counter_core: random and directed
// byte ranges against a cycle-free column and split-offset predictor.
// Depends on ucw_pkg and the utf8_column_width_counter_core RTL.
module utf8_column_width_counter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ucw_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 7;
  // Results pass through the queue and the output register; allow a generous margin.
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;

  // How a range of beats is closed when it goes to the driver
  localparam int CLOSE_OPEN    = 0;  // leave the range running
  localparam int CLOSE_ON_BYTE = 1;  // flag last_byte on the final beat
  localparam int CLOSE_EXTRA   = 2;  // append a byte-less closing beat

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  utf8_column_width_counter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Column predictor: mirrors the decode state of the block, one beat at a time
  // ---------------------------------------------------------------------------
  logic [1:0]      seq_need     = '0;  // continuations the pending lead asks for
  logic [1:0]      seq_held     = '0;  // continuations gathered so far
  code_t           seq_code     = '0;
  longint unsigned seq_lead     = 0;   // offset of the pending lead
  longint unsigned range_len    = 0;   // offset of the next byte
  longint unsigned column_sum   = 0;
  longint unsigned split_at     = 0;
  bit              split_hit    = 1'b0;
  longint unsigned column_limit = 0;   // shadow of target_column

  out_item_t column_tallies[$];        // expected results, oldest first

  function automatic longint unsigned clamp_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > CNT_MAX) ? CNT_MAX : s;
  endfunction

  function automatic int unsigned glyph_columns(code_t cp);
    if (cp == 21'h0) return 0;
    if ((cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
        (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
        (cp >= 21'hFE20 && cp <= 21'hFE2F))
      return 0;
    if (cp >= 21'h200B && cp <= 21'h200D) return 0;
    if ((cp >= 21'h17B6 && cp <= 21'h17D3) || cp == 21'h17DD) return 0;
    return 1;
  endfunction

  // Add one code point; latch the split offset the first time the limit is crossed.
  function automatic void add_glyph(int unsigned w, longint unsigned pos);
    if (!split_hit && column_sum + w > column_limit) begin
      split_hit = 1'b1;
      split_at  = pos;
    end
    column_sum = clamp_add(column_sum, w);
  endfunction

  // Break a pending sequence into width-1 code points at their own offsets.
  function automatic void spill_sequence();
    int k;
    if (seq_need == 2'd0) return;
    for (k = 0; k <= seq_held; k++) add_glyph(1, clamp_add(seq_lead, k));
    seq_need = '0;
    seq_held = '0;
    seq_code = '0;
  endfunction

  function automatic void decode_byte(logic [7:0] b, longint unsigned pos);
    if (seq_need != 2'd0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        seq_code = {seq_code[14:0], b[5:0]};
        seq_held = seq_held + 2'd1;
        if (seq_held >= seq_need) begin
          add_glyph(glyph_columns(seq_code), seq_lead);
          seq_need = '0;
          seq_held = '0;
          seq_code = '0;
        end
        return;
      end
      // Not a continuation: resolve the broken sequence, then restart on this byte.
      spill_sequence();
    end
    if ((b & ASCII_MASK) == 8'h00) begin
      add_glyph(glyph_columns({13'd0, b}), pos);
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      seq_need = 2'd1;
      seq_code = {16'd0, b[4:0]};
      seq_lead = pos;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      seq_need = 2'd2;
      seq_code = {17'd0, b[3:0]};
      seq_lead = pos;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      seq_need = 2'd3;
      seq_code = {18'd0, b[2:0]};
      seq_lead = pos;
    end else begin
      // Stray continuation or 0xF8..0xFF: a lone width-1 code point
      add_glyph(1, pos);
    end
    seq_held = '0;
  endfunction

  function automatic void tally_beat(in_item_t beat);
    out_item_t res;
    if (beat.has_byte) begin
      decode_byte(beat.data_byte, range_len);
      range_len = clamp_add(range_len, 1);
    end
    if (!beat.last_byte) return;
    // Range end is end of text: a cut sequence resolves like a bad continuation.
    spill_sequence();
    res.column_total   = column_sum[15:0];
    res.split_offset   = split_hit ? split_at[15:0] : range_len[15:0];
    res.target_reached = split_hit;
    column_tallies.push_back(res);
    seq_lead   = 0;
    range_len  = 0;
    column_sum = 0;
    split_at   = 0;
    split_hit  = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor and watchdog
  // ---------------------------------------------------------------------------
  in_item_t  byte_backlog[$];   // beats waiting for the driver
  in_item_t  range_buf[$];      // range under construction
  out_item_t want;
  int beats_queued   = 0;
  int beats_taken    = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int stimulus_items = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  // Predict on acceptance; hold valid and payload until the beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tally_beat(in_data);
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each result beat against the oldest prediction; stall the receiver at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (column_tallies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result beat: total=%0d offset=%0d reached=%0d",
                   out_data.column_total, out_data.split_offset, out_data.target_reached);
      end else begin
        want = column_tallies.pop_front();
        if (out_data.column_total !== want.column_total ||
            out_data.split_offset !== want.split_offset ||
            out_data.target_reached !== want.target_reached) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"result %0d mismatch: expected total=%0d offset=%0d reached=%0d,",
                      " got total=%0d offset=%0d reached=%0d"},
                     results_seen, want.column_total, want.split_offset,
                     want.target_reached, out_data.column_total,
                     out_data.split_offset, out_data.target_reached);
        end
        results_seen++;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Count cycles without any handshake; give up once the block looks hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("utf8_column_width_counter_core verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    range_buf.push_back('{data_byte: b, has_byte: 1'b1, last_byte: 1'b0});
  endfunction

  // A beat without a byte that the block must ignore
  function automatic void put_gap();
    range_buf.push_back('{data_byte: 8'($urandom), has_byte: 1'b0, last_byte: 1'b0});
  endfunction

  function automatic int utf8_len(code_t cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Encode into n bytes; a length above the minimum gives an overlong form.
  function automatic void encode_cp(code_t cp, int n);
    case (n)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Zero-width code points, with the range edges and their neighbors favored
  function automatic code_t pick_zero_width();
    int unsigned lo, hi;
    case ($urandom_range(0, 6))
      0: begin lo = 'h0300; hi = 'h036F; end
      1: begin lo = 'h1AB0; hi = 'h1AFF; end
      2: begin lo = 'h1DC0; hi = 'h1DFF; end
      3: begin lo = 'h20D0; hi = 'h20FF; end
      4: begin lo = 'hFE20; hi = 'hFE2F; end
      5: begin lo = 'h200B; hi = 'h200D; end
      default: begin lo = 'h17B6; hi = 'h17D3; end
    endcase
    case ($urandom_range(0, 7))
      0: return code_t'(lo - 1);
      1: return code_t'(lo);
      2: return code_t'(hi);
      3: return code_t'(hi + 1);
      4: return code_t'($urandom_range('h17DC, 'h17DE));
      default: return code_t'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic void add_random_unit();
    int unsigned pick, need, cut;
    code_t cp;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      put_byte(8'($urandom_range(0, 127)));
    end else if (pick < 31) begin
      put_byte(8'h00);
    end else if (pick < 44) begin
      encode_cp(code_t'($urandom_range('h80, 'h7FF)), 2);
    end else if (pick < 56) begin
      cp = pick_zero_width();
      encode_cp(cp, utf8_len(cp));
    end else if (pick < 64) begin
      // Includes the surrogate block, which decodes unchecked
      encode_cp(code_t'($urandom_range('h800, 'hFFFF)), 3);
    end else if (pick < 71) begin
      encode_cp(code_t'($urandom_range('h10000, 'h1FFFFF)), 4);
    end else if (pick < 75) begin
      encode_cp(code_t'($urandom_range(0, 'h7F)), $urandom_range(2, 4));
    end else if (pick < 82) begin
      put_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                    : 8'($urandom_range('hF8, 'hFF)));
    end else if (pick < 94) begin
      // Drop trailing continuations so the next byte or the range end breaks it
      need = $urandom_range(1, 3);
      encode_cp(code_t'($urandom_range(0, 'h1FFFFF)), need + 1);
      cut = $urandom_range(1, need);
      repeat (cut) void'(range_buf.pop_back());
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // Close the range as asked and hand its beats to the driver.
  function automatic void ship_range(int close_mode);
    in_item_t beat;
    if (close_mode == CLOSE_ON_BYTE && range_buf.size() != 0) begin
      beat = range_buf.pop_back();
      beat.last_byte = 1'b1;
      range_buf.push_back(beat);
    end else if (close_mode != CLOSE_OPEN) begin
      range_buf.push_back('{data_byte: 8'($urandom), has_byte: 1'b0, last_byte: 1'b1});
    end
    while (range_buf.size() != 0) begin
      beat = range_buf.pop_front();
      if (beat.has_byte || beat.last_byte) stimulus_items++;
      byte_backlog.push_back(beat);
      beats_queued++;
    end
  endfunction

  function automatic void queue_random_ranges(int quota);
    int goal, units;
    goal = stimulus_items + quota;
    while (stimulus_items < goal) begin
      // Mostly short ranges, now and then a longer one; zero units gives an empty range
      units = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      repeat (units) begin
        add_random_unit();
        if ($urandom_range(0, 99) < 5) put_gap();
      end
      ship_range(($urandom_range(0, 99) < 70) ? CLOSE_ON_BYTE : CLOSE_EXTRA);
    end
  endfunction

  // Write target_column through its channel and update the shadow on acceptance.
  task automatic program_target(input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    column_limit = value;
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Drain every queued beat and expected result, then let the pipeline settle.
  task automatic wait_idle();
    while (beats_taken != beats_queued || column_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles in about a fifth of the cycles, receiver in half.
    send_idle_pct = 21;
    recv_idle_pct = 50;
    program_target(16'd2);

    // Directed: ASCII with NUL and DEL, a 2-byte letter, a combining mark, a
    // zero-width space, a Khmer sign and a 4-byte emoji; the split lands mid-range.
    put_byte(8'h41);
    put_byte(8'h00);
    put_byte(8'h7F);
    encode_cp(21'h00E9, 2);
    encode_cp(21'h0301, 2);
    encode_cp(21'h200B, 3);
    encode_cp(21'h17B6, 3);
    encode_cp(21'h1F600, 4);
    ship_range(CLOSE_ON_BYTE);
    // Directed: a stray continuation, invalid leads, a lead broken by ASCII, and a cut 4-byte sequence.
    put_byte(8'h80);
    put_byte(8'hFF);
    put_byte(8'hF8);
    put_byte(8'hE2);
    put_byte(8'h41);
    put_byte(8'hF0);
    put_byte(8'h9F);
    ship_range(CLOSE_ON_BYTE);
    // Directed: an ignored beat, then an empty range.
    put_gap();
    ship_range(CLOSE_EXTRA);
    queue_random_ranges(100);
    wait_idle();

    program_target(16'hFFFF);
    queue_random_ranges(80);
    wait_idle();

    // Swap the idle ratios.
    send_idle_pct = 50;
    recv_idle_pct = 21;
    program_target(16'd0);
    queue_random_ranges(50);
    // Leave a sequence hanging, pause until all results are in, then resume it.
    put_byte(8'hE1);
    put_byte(8'h9F);
    ship_range(CLOSE_OPEN);
    wait_idle();
    put_byte(8'h9D);
    queue_random_ranges(50);
    wait_idle();

    program_target(16'($urandom_range(1, 24)));
    queue_random_ranges(80);
    wait_idle();

    // No idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_target(16'($urandom_range(0, 16'hFFFF)));
    queue_random_ranges(80);
    wait_idle();

    program_target(16'd5);
    queue_random_ranges(80);
    wait_idle();

    mismatch_count += column_tallies.size();
    $display("Summary: %0d input beats, %0d range results, %0d target_column writes",
             beats_taken, results_seen, cfg_writes);
    $display("Summary: directed decode cases and random ranges under three idle mixes");
    if (mismatch_count == 0) begin
      $display("utf8_column_width_counter_core verification clean");
    end else begin
      $display("utf8_column_width_counter_core verification failed");
    end
    $finish;
  end

endmodule
